[hw/rtl/sc1_pkg.sv]
// ----------------------------------------------------------------------------
// SHACAL-1 shared package
// Types, constants and round helper functions for the SHACAL-1 block cipher.
// ----------------------------------------------------------------------------
package sc1_pkg;

	localparam int ROUNDS    = 80;
	localparam int KEY_WORDS = 16;
	localparam int NUM_RC    = 4;
	localparam int GROUP_LEN = 20;
	localparam int RND_W     = $clog2(ROUNDS);
	localparam int KEY_W     = $clog2(KEY_WORDS);
	localparam int RC_W      = $clog2(NUM_RC);

	localparam logic [31:0] RC_RESET [NUM_RC] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_ENC  = 2'd1,
		OP_DEC  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [RC_W-1:0] {
		GRP_CHOOSE  = 2'd0,
		GRP_PARITY  = 2'd1,
		GRP_MAJ     = 2'd2,
		GRP_PARITY2 = 2'd3
	} grp_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} blk_t;

	typedef struct packed {
		logic             bld_en;
		logic [RND_W-1:0] bld_idx;
		logic             rd_en;
		logic [RND_W-1:0] rd_addr;
	} sched_ctl_t;

	function automatic grp_t round_grp(input logic [RND_W-1:0] r);
		grp_t g;
		if (r < RND_W'(GROUP_LEN))
			g = GRP_CHOOSE;
		else if (r < RND_W'(2 * GROUP_LEN))
			g = GRP_PARITY;
		else if (r < RND_W'(3 * GROUP_LEN))
			g = GRP_MAJ;
		else
			g = GRP_PARITY2;
		return g;
	endfunction

	function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input grp_t g);
		logic [31:0] f;
		case (g)
			GRP_CHOOSE: f = (x & y) | (~x & z);
			GRP_MAJ:    f = (x & y) | (x & z) | (y & z);
			default:    f = x ^ y ^ z;
		endcase
		return f;
	endfunction

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		return {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] rotl2(input logic [31:0] x);
		return {x[29:0], x[31:30]};
	endfunction

	function automatic logic [31:0] rotl5(input logic [31:0] x);
		return {x[26:0], x[31:27]};
	endfunction

	function automatic logic [31:0] rotl30(input logic [31:0] x);
		return {x[1:0], x[31:2]};
	endfunction

endpackage

[hw/rtl/sc1_round.sv]
// ----------------------------------------------------------------------------
// SHACAL-1 round unit
// One encrypt or inverse round on the five-word state, shared by all rounds.
// ----------------------------------------------------------------------------
module sc1_round import sc1_pkg::*; (
	input  blk_t        st,
	input  logic        dec,
	input  grp_t        grp,
	input  logic [31:0] k,
	input  logic [31:0] w,
	output blk_t        nx
);

	logic [31:0] nb_dec;

	assign nb_dec = rotl2(st.c);

	always_comb begin
		if (dec) begin
			nx.a = st.b;
			nx.b = nb_dec;
			nx.c = st.d;
			nx.d = st.e;
			nx.e = st.a - rotl5(st.b) - mix(nb_dec, st.d, st.e, grp) - k - w;
		end else begin
			nx.a = rotl5(st.a) + mix(st.b, st.c, st.d, grp) + st.e + k + w;
			nx.b = st.a;
			nx.c = rotl30(st.b);
			nx.d = st.c;
			nx.e = st.d;
		end
	end

endmodule

[hw/rtl/sc1_sched.sv]
// ----------------------------------------------------------------------------
// SHACAL-1 key schedule
// Expands the key one word per cycle while bld_en is set, through a 16-word
// window into an 80-entry schedule memory with a registered read port.
// ----------------------------------------------------------------------------
module sc1_sched import sc1_pkg::*; (
	input  logic        clk,
	input  sched_ctl_t  ctl,
	input  logic [31:0] key_word,
	output logic [31:0] rd_data
);

	logic [31:0] mem [ROUNDS];
	logic [31:0] win_q [KEY_WORDS];
	logic [31:0] w_new;

	always_comb begin
		if (ctl.bld_idx < RND_W'(KEY_WORDS))
			w_new = key_word;
		else
			w_new = rotl1(win_q[2] ^ win_q[7] ^ win_q[13] ^ win_q[15]);
	end

	always_ff @(posedge clk) begin
		if (ctl.bld_en) begin
			mem[ctl.bld_idx] <= w_new;
			win_q[0] <= w_new;
			for (int i = 1; i < KEY_WORDS; i++)
				win_q[i] <= win_q[i-1];
		end
		if (ctl.rd_en)
			rd_data <= mem[ctl.rd_addr];
	end

endmodule

[hw/rtl/shacal1_block_cipher.sv]
// ----------------------------------------------------------------------------
// SHACAL-1 block cipher
// 160-bit block, 80 rounds, one round per cycle on a shared round unit.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   op, key_index, key_value, in_a..in_e
//   out      out  out_valid/out_stall out_a..out_e
//   cfg      in   cfg_we              cfg_index, cfg_data (round constants)
//
// Encrypt/decrypt: after accept a block passes the prefetch step, the 80
// rounds on the single round unit and the result load; the core then
// returns to idle for the next word. A key load leaves the core idle.
// The first block after reset or a key load first rebuilds the schedule,
// one schedule word per cycle for all 80 words.
// in_stall is high while a block is at work; a result held by out_stall
// holds back the next block at its last step only.
// ----------------------------------------------------------------------------
module shacal1_block_cipher import sc1_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [RC_W-1:0]     cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          op,
	input  logic [KEY_W-1:0]    key_index,
	input  logic [31:0]         key_value,
	input  logic [31:0]         in_a,
	input  logic [31:0]         in_b,
	input  logic [31:0]         in_c,
	input  logic [31:0]         in_d,
	input  logic [31:0]         in_e,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         out_a,
	output logic [31:0]         out_b,
	output logic [31:0]         out_c,
	output logic [31:0]         out_d,
	output logic [31:0]         out_e
);

	typedef enum logic [4:0] {
		ST_IDLE     = 5'b00001,
		ST_REBUILD  = 5'b00010,
		ST_PREFETCH = 5'b00100,
		ST_ROUND    = 5'b01000,
		ST_DONE     = 5'b10000
	} state_t;

	state_t           state_q;
	logic [31:0]      rc_q [NUM_RC];
	logic [31:0]      key_q [KEY_WORDS];
	logic             stale_q;
	logic             dec_q;
	logic [RND_W-1:0] rnd_q;
	logic             out_valid_q;
	blk_t             st_q;
	blk_t             out_q;
	blk_t             st_nx;
	sched_ctl_t       sctl;
	logic [31:0]      w_rd;
	grp_t             grp;
	logic             in_acc;
	logic             blk_acc;
	logic             last_rnd;
	logic             load_out;
	logic [RND_W-1:0] first_rnd;
	logic [RND_W-1:0] next_rnd;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign blk_acc   = in_acc && (op == OP_ENC || op == OP_DEC);
	assign grp       = round_grp(rnd_q);
	assign last_rnd  = dec_q ? (rnd_q == '0) : (rnd_q == RND_W'(ROUNDS - 1));
	assign first_rnd = dec_q ? RND_W'(ROUNDS - 1) : '0;
	assign next_rnd  = last_rnd ? rnd_q : (dec_q ? rnd_q - 1'b1 : rnd_q + 1'b1);
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		sctl.bld_en  = (state_q == ST_REBUILD);
		sctl.bld_idx = rnd_q;
		sctl.rd_en   = (state_q == ST_PREFETCH) || (state_q == ST_ROUND);
		sctl.rd_addr = (state_q == ST_PREFETCH) ? first_rnd : next_rnd;
	end

	sc1_sched u_sched (
		.clk      (clk),
		.ctl      (sctl),
		.key_word (key_q[rnd_q[KEY_W-1:0]]),
		.rd_data  (w_rd)
	);

	sc1_round u_round (
		.st  (st_q),
		.dec (dec_q),
		.grp (grp),
		.k   (rc_q[grp]),
		.w   (w_rd),
		.nx  (st_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RC; i++)
				rc_q[i] <= RC_RESET[i];
		end else if (cfg_we) begin
			rc_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++)
				key_q[i] <= '0;
		end else if (in_acc && op == OP_LOAD) begin
			key_q[key_index] <= key_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stale_q     <= 1'b1;
			dec_q       <= 1'b0;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && op == OP_LOAD)
						stale_q <= 1'b1;
					if (blk_acc) begin
						dec_q   <= (op == OP_DEC);
						rnd_q   <= '0;
						state_q <= stale_q ? ST_REBUILD : ST_PREFETCH;
					end
				end
				ST_REBUILD: begin
					if (rnd_q == RND_W'(ROUNDS - 1)) begin
						stale_q <= 1'b0;
						state_q <= ST_PREFETCH;
					end else begin
						rnd_q <= rnd_q + 1'b1;
					end
				end
				ST_PREFETCH: begin
					rnd_q   <= first_rnd;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= next_rnd;
					if (last_rnd)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (blk_acc)
			st_q <= '{a: in_a, b: in_b, c: in_c, d: in_d, e: in_e};
		else if (state_q == ST_ROUND)
			st_q <= st_nx;
		if (load_out)
			out_q <= st_q;
	end

	assign out_valid = out_valid_q;
	assign out_a     = out_q.a;
	assign out_b     = out_q.b;
	assign out_c     = out_q.c;
	assign out_d     = out_q.d;
	assign out_e     = out_q.e;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result word raised outside the done step");

	a_rounds_need_schedule: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREFETCH || state_q == ST_ROUND) |-> !stale_q)
		else $error("rounds run on a stale schedule");

	a_key_load_stales: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && op == OP_LOAD) |=> stale_q)
		else $error("key load did not mark the schedule stale");

	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (rnd_q < RND_W'(ROUNDS)))
		else $error("round counter out of range");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// SHACAL-1 block cipher testbench
// Drives key-load, encrypt, decrypt and unused words with random idling on
// both sides. A local cipher model predicts each result block, and the
// checker compares every output word against the oldest prediction.
// Round constants are changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sc1_pkg::*;

	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_WORDS    = 340;
	localparam int BURST_WORDS    = 240;
	localparam int REPORT_MAX     = 10;
	localparam int IDLE_PCT       = 37;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] kidx;
		logic [31:0]      kval;
		blk_t             blk;
	} cmd_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [RC_W-1:0]  cfg_index;
	logic [31:0]      cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       op;
	logic [KEY_W-1:0] key_index;
	logic [31:0]      key_value;
	logic [31:0]      in_a, in_b, in_c, in_d, in_e;
	logic             out_valid;
	logic             out_stall;
	logic [31:0]      out_a, out_b, out_c, out_d, out_e;

	// cipher model state
	logic [31:0] key_words [KEY_WORDS];
	logic [31:0] sched_words [ROUNDS];
	bit          sched_stale;
	logic [31:0] round_k [NUM_RC];
	blk_t        last_cipher;
	blk_t        expected_blocks [$];

	int mismatches;
	int idle_cycles;
	int counted_words;
	bit no_idle;

	shacal1_block_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.key_index (key_index),
		.key_value (key_value),
		.in_a      (in_a),
		.in_b      (in_b),
		.in_c      (in_c),
		.in_d      (in_d),
		.in_e      (in_e),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_a     (out_a),
		.out_b     (out_b),
		.out_c     (out_c),
		.out_d     (out_d),
		.out_e     (out_e)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] rol(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] round_fn(input logic [31:0] x, y, z, input int r);
		if (r < GROUP_LEN)
			return (x & y) | (~x & z);
		if (r >= 2 * GROUP_LEN && r < 3 * GROUP_LEN)
			return (x & y) | (x & z) | (y & z);
		return x ^ y ^ z;
	endfunction

	function automatic void expand_key();
		for (int i = 0; i < ROUNDS; i++) begin
			if (i < KEY_WORDS)
				sched_words[i] = key_words[i];
			else
				sched_words[i] = rol(sched_words[i-3] ^ sched_words[i-8] ^
					sched_words[i-14] ^ sched_words[i-16], 1);
		end
		sched_stale = 1'b0;
	endfunction

	function automatic blk_t cipher_fwd(input blk_t p);
		blk_t s;
		logic [31:0] t;
		s = p;
		for (int r = 0; r < ROUNDS; r++) begin
			t = rol(s.a, 5) + round_fn(s.b, s.c, s.d, r) + s.e +
				round_k[r / GROUP_LEN] + sched_words[r];
			s.e = s.d;
			s.d = s.c;
			s.c = rol(s.b, 30);
			s.b = s.a;
			s.a = t;
		end
		return s;
	endfunction

	function automatic blk_t cipher_inv(input blk_t p);
		blk_t s, n;
		s = p;
		for (int r = ROUNDS - 1; r >= 0; r--) begin
			n.a = s.b;
			n.b = rol(s.c, 2);
			n.c = s.d;
			n.d = s.e;
			n.e = s.a - rol(n.a, 5) - round_fn(n.b, n.c, n.d, r) -
				round_k[r / GROUP_LEN] - sched_words[r];
			s = n;
		end
		return s;
	endfunction

	function automatic void apply_word(input cmd_t w);
		blk_t res;
		case (w.op)
			OP_LOAD: begin
				key_words[w.kidx] = w.kval;
				sched_stale = 1'b1;
			end
			OP_ENC, OP_DEC: begin
				if (sched_stale)
					expand_key();
				if (w.op == OP_ENC) begin
					res = cipher_fwd(w.blk);
					last_cipher = res;
				end else begin
					res = cipher_inv(w.blk);
				end
				expected_blocks.insert(expected_blocks.size(), res);
			end
			default: ;
		endcase
	endfunction

	function automatic cmd_t mk_word(input op_t o, input logic [KEY_W-1:0] i,
		input logic [31:0] v, input blk_t b);
		cmd_t w;
		w.op   = o;
		w.kidx = i;
		w.kval = v;
		w.blk  = b;
		return w;
	endfunction

	// biased toward all-zero and all-one words
	function automatic logic [31:0] rand_word();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return $urandom;
	endfunction

	function automatic blk_t rand_block();
		return {rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
	endfunction

	task automatic send_word(input cmd_t w);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		op        <= w.op;
		key_index <= w.kidx;
		key_value <= w.kval;
		in_a      <= w.blk.a;
		in_b      <= w.blk.b;
		in_c      <= w.blk.c;
		in_d      <= w.blk.d;
		in_e      <= w.blk.e;
		do @(posedge clk); while (in_stall);
		apply_word(w);
		if (w.op != OP_NONE)
			counted_words++;
	endtask

	task automatic send_block();
		blk_t b;
		if ($urandom_range(1)) begin
			send_word(mk_word(OP_ENC, KEY_W'($urandom), $urandom, rand_block()));
		end else begin
			b = ($urandom_range(2) == 0) ? last_cipher : rand_block();
			send_word(mk_word(OP_DEC, KEY_W'($urandom), $urandom, b));
		end
	endtask

	task automatic send_key_word(input logic [KEY_W-1:0] idx);
		send_word(mk_word(OP_LOAD, idx, rand_word(), rand_block()));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_blocks.size() != 0)
			@(posedge clk);
		// key loads give no result; let the core settle
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_constants(input logic [31:0] k0, k1, k2, k3);
		logic [31:0] k [NUM_RC];
		k = '{k0, k1, k2, k3};
		for (int i = 0; i < NUM_RC; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= RC_W'(i);
			cfg_data  <= k[i];
			round_k[i] = k[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random_phase(input int target);
		int start;
		int roll;
		start = counted_words;
		while (counted_words - start < target) begin
			roll = $urandom_range(99);
			if (roll < 40) begin
				for (int i = 0; i < KEY_WORDS; i++)
					send_key_word(KEY_W'(i));
				repeat ($urandom_range(1, 4)) send_block();
			end else if (roll < 70) begin
				repeat ($urandom_range(1, 6)) send_block();
			end else if (roll < 85) begin
				repeat ($urandom_range(1, 3)) send_key_word(KEY_W'($urandom));
				repeat ($urandom_range(1, 3)) send_block();
			end else if (roll < 93) begin
				send_word(mk_word(OP_NONE, KEY_W'($urandom), $urandom, rand_block()));
			end else begin
				// key load cut short, no block follows
				repeat ($urandom_range(1, KEY_WORDS - 1)) send_key_word(KEY_W'($urandom));
			end
		end
	endtask

	task automatic test_directed();
		send_word(mk_word(OP_ENC, '0, '0, '0));
		send_word(mk_word(OP_DEC, '1, '1, '0));
		send_word(mk_word(OP_ENC, '0, '0, '1));
		send_word(mk_word(OP_NONE, '1, '1, '1));
		send_word(mk_word(OP_LOAD, '0, '1, '1));
		send_word(mk_word(OP_NONE, '0, '0, '0));
		send_word(mk_word(OP_LOAD, '1, 32'h8000_0001, '0));
		send_word(mk_word(OP_ENC, '1, '1,
			{32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210, 32'hF0E1_D2C3}));
		send_word(mk_word(OP_DEC, '0, '0, last_cipher));
		send_word(mk_word(OP_DEC, '0, '0, '1));
		send_word(mk_word(OP_ENC, '0, '0,
			{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}));
		send_word(mk_word(OP_LOAD, 4'd7, '0, '1));
		send_word(mk_word(OP_ENC, '0, '0, last_cipher));
	endtask

	task automatic test_round_constants();
		drain();
		write_constants('0, '0, '0, '0);
		repeat (3) send_block();
		drain();
		write_constants('1, '1, '1, '1);
		repeat (3) send_block();
		drain();
		write_constants($urandom, $urandom, $urandom, $urandom);
		repeat (3) send_block();
	endtask

	task automatic test_random();
		run_random_phase(PHASE_WORDS);
		drain();
		write_constants($urandom, $urandom, $urandom, $urandom);
		run_random_phase(PHASE_WORDS);
		drain();
		run_random_phase(PHASE_WORDS);
		drain();
		write_constants(RC_RESET[0], RC_RESET[1], RC_RESET[2], RC_RESET[3]);
		run_random_phase(PHASE_WORDS);
	endtask

	task automatic test_back_to_back();
		no_idle = 1'b1;
		run_random_phase(BURST_WORDS);
		no_idle = 1'b0;
	endtask

	always @(negedge clk)
		out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);

	always @(posedge clk) begin
		blk_t got, want;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (out_valid && !out_stall) begin
				got = {out_a, out_b, out_c, out_d, out_e};
				if (expected_blocks.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: unexpected result %h %h %h %h %h", $time,
							got.a, got.b, got.c, got.d, got.e);
				end else begin
					want = expected_blocks.pop_front();
					if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
						got.d !== want.d || got.e !== want.e) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("%0t: exp %h %h %h %h %h got %h %h %h %h %h", $time,
								want.a, want.b, want.c, want.d, want.e,
								got.a, got.b, got.c, got.d, got.e);
					end
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		op          = OP_NONE;
		key_index   = '0;
		key_value   = '0;
		in_a        = '0;
		in_b        = '0;
		in_c        = '0;
		in_d        = '0;
		in_e        = '0;
		out_stall   = 1'b0;
		mismatches  = 0;
		idle_cycles = 0;
		no_idle     = 1'b0;
		sched_stale = 1'b1;
		last_cipher = '0;
		counted_words = 0;
		foreach (key_words[i])
			key_words[i] = '0;
		foreach (round_k[i])
			round_k[i] = RC_RESET[i];
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_round_constants();
		test_random();
		test_back_to_back();
		drain();

		mismatches += expected_blocks.size();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
